// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by atkinson_dither_unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/atd_pkg.sv =====
// ---------------------------------------------------------------------------
// atd_pkg
// types, constants and arithmetic helpers of the atkinson dither unit
// ---------------------------------------------------------------------------
package atd_pkg;

  localparam int GRAY_W      = 8;
  localparam int DIFF_W      = 5;
  localparam int CFG_W       = 10;
  localparam int RESET_WIDTH = 360;
  localparam int MIN_WIDTH   = 3;

  typedef logic [GRAY_W-1:0]        gray_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // one column of the line stores: a is the row above, b the row two above
  typedef struct packed {
    diff_t a;
    diff_t b;
  } line_word_t;

  // add a signed diff and clamp the sum to 0..255
  function automatic gray_t add_clamped(gray_t v, diff_t d);
    logic signed [GRAY_W+1:0] s;
    s = $signed({2'b00, v}) + $signed({{(GRAY_W+2-DIFF_W){d[DIFF_W-1]}}, d});
    if (s[GRAY_W+1]) begin
      return '0;
    end else if (s[GRAY_W]) begin
      return '1;
    end else begin
      return s[GRAY_W-1:0];
    end
  endfunction

  // quantization error over 8, truncated toward zero
  function automatic diff_t error_diff(gray_t v);
    gray_t nv;
    nv = ~v;
    if (!v[GRAY_W-1]) begin
      return $signed({1'b0, v[GRAY_W-2:3]});
    end else begin
      return -$signed({1'b0, nv[GRAY_W-2:3]});
    end
  endfunction

endpackage

// ===== design/atd_pix_if.sv =====
// ---------------------------------------------------------------------------
// atd_pix_if
// gray pixel channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface atd_pix_if
  import atd_pkg::*;
;
  logic  valid;
  logic  ready;
  gray_t gray_level;
  logic  frame_start;

  modport source (output valid, output gray_level, output frame_start, input ready);
  modport sink   (input valid, input gray_level, input frame_start, output ready);
endinterface

// ===== design/atd_dot_if.sv =====
// ---------------------------------------------------------------------------
// atd_dot_if
// dithered dot channel with valid/ready handshake
// ---------------------------------------------------------------------------
interface atd_dot_if;
  logic valid;
  logic ready;
  logic dot_black;
  logic row_end;

  modport source (output valid, output dot_black, output row_end, input ready);
  modport sink   (input valid, input dot_black, input row_end, output ready);
endinterface

// ===== design/atd_ram.sv =====
// ---------------------------------------------------------------------------
// atd_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module atd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/atkinson_dither_unit.sv =====
// ---------------------------------------------------------------------------
// atkinson_dither_unit
// streaming atkinson error diffusion: gray pixels in, black/white dots out
// ---------------------------------------------------------------------------
// usage:
//   pix_in carries gray_level and frame_start in raster order; frame_start
//   marks the first pixel of an image. dot_out returns one dot per pixel,
//   dot_black plus row_end on the last pixel of each row.
//   cfg_we/cfg_data set image_width (clamped to 3..MAX_WIDTH); write it only
//   while no pixel is in flight. it applies from the next pixel on.
// timing:
//   one pixel per clock sustained while dot_out accepts. a result is in the
//   output register in the cycle after the input transfer. the per-pixel
//   loop is a read-modify-write of the line stores, kept fed by prefetching
//   the next column pair with write forwarding.
//   line stores sit in two 1r1w rams (depth MAX_WIDTH); they need no
//   clearing after reset since a frame reads only entries it wrote.
// reset and stall:
//   rst clears column, row count, in-row error registers and output valid.
//   when dot_out stalls, the result holds and pix_in.ready drops until the
//   held result transfers; the next pixel can enter in that same cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module atkinson_dither_unit
  import atd_pkg::*;
#(
  parameter int MAX_WIDTH = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  atd_pix_if.sink          pix_in,
  atd_dot_if.source        dot_out
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > CFG_W) ? CW : CFG_W;
  localparam int RST_LAST = (RESET_WIDTH < MIN_WIDTH) ? (MIN_WIDTH - 1) :
                            (RESET_WIDTH > MAX_WIDTH) ? (MAX_WIDTH - 1) : (RESET_WIDTH - 1);

  logic [AW-1:0] column, column_next;
  logic [1:0]    rows_done, rows_done_next, rows_eff;
  logic [AW-1:0] last_col;
  diff_t         diff_prev, diff_two_back, a_m1;

  logic          pend_valid;
  logic [AW-1:0] pend_addr;
  line_word_t    pend_word;

  logic          fwd0, fwd1;
  line_word_t    fwd_word;

  logic          out_valid, out_black, out_row_end;

  logic          acc, last, x_ge1, x_ge2, use_a, use_b;
  logic [AW-1:0] x;
  line_word_t    rd0_word, cur_word;
  diff_t         rd1_a, next_a, d;
  gray_t         v1, v2, v3, v4, v5, v6;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;
  line_word_t    wr_word;

  logic [WW-1:0] cfg_w, cfg_wm1;
  logic [AW-1:0] cfg_last;

  // width register holds the last column index
  always_comb begin
    cfg_w   = WW'(cfg_data);
    cfg_wm1 = cfg_w - WW'(1);
    if (cfg_w < WW'(MIN_WIDTH)) begin
      cfg_last = AW'(MIN_WIDTH - 1);
    end else if (cfg_w > WW'(MAX_WIDTH)) begin
      cfg_last = AW'(MAX_WIDTH - 1);
    end else begin
      cfg_last = cfg_wm1[AW-1:0];
    end
  end

  assign acc          = pix_in.valid & pix_in.ready;
  assign pix_in.ready = ~out_valid | dot_out.ready;

  assign x        = pix_in.frame_start ? '0 : column;
  assign rows_eff = pix_in.frame_start ? 2'd0 : rows_done;
  assign last     = (x >= last_col);
  assign x_ge1    = (x != '0);
  assign x_ge2    = (x > AW'(1));
  assign use_a    = (rows_eff != 2'd0);
  assign use_b    = rows_eff[1];

  assign cur_word = fwd0 ? fwd_word : rd0_word;
  assign next_a   = fwd1 ? fwd_word.a : rd1_a;

  // diffs applied oldest source first, each add clamped
  always_comb begin
    v1 = add_clamped(pix_in.gray_level, use_b ? cur_word.b : diff_t'(0));
    v2 = add_clamped(v1, (use_a && x_ge1) ? a_m1 : diff_t'(0));
    v3 = add_clamped(v2, use_a ? cur_word.a : diff_t'(0));
    v4 = add_clamped(v3, (use_a && !last) ? next_a : diff_t'(0));
    v5 = add_clamped(v4, x_ge2 ? diff_two_back : diff_t'(0));
    v6 = add_clamped(v5, x_ge1 ? diff_prev : diff_t'(0));
    d  = error_diff(v6);
  end

  // write port: the deferred last-column write goes first, the next pixel
  // is then column zero and writes nothing
  always_comb begin
    if (pend_valid) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_word = pend_word;
    end else begin
      wr_en   = acc && x_ge1;
      wr_addr = x - AW'(1);
      wr_word = '{a: diff_prev, b: a_m1};
    end
  end

  always_comb begin
    column_next    = column;
    rows_done_next = rows_done;
    if (acc) begin
      column_next    = last ? '0 : x + AW'(1);
      rows_done_next = rows_eff;
      if (last && !rows_eff[1]) begin
        rows_done_next = rows_eff + 2'd1;
      end
    end
  end

  // prefetch the column pair of the next pixel
  assign rd_addr0 = column_next;
  assign rd_addr1 = column_next + AW'(1);

  atd_ram #(
    .WIDTH ($bits(line_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .raddr (rd_addr0),
    .rdata (rd0_word)
  );

  atd_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (MAX_WIDTH)
  ) u_ahead_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_word.a),
    .raddr (rd_addr1),
    .rdata (rd1_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      rows_done     <= 2'd0;
      last_col      <= AW'(RST_LAST);
      diff_prev     <= '0;
      diff_two_back <= '0;
      pend_valid    <= 1'b0;
      fwd0          <= 1'b0;
      fwd1          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      column     <= column_next;
      rows_done  <= rows_done_next;
      pend_valid <= acc && last;
      fwd0       <= wr_en && (wr_addr == rd_addr0);
      fwd1       <= wr_en && (wr_addr == rd_addr1);
      if (cfg_we) begin
        last_col <= cfg_last;
      end
      if (acc) begin
        diff_two_back <= pix_in.frame_start ? diff_t'(0) : diff_prev;
        diff_prev     <= d;
        out_valid     <= 1'b1;
      end else if (dot_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_word <= wr_word;
    if (acc) begin
      a_m1        <= cur_word.a;
      pend_addr   <= x;
      pend_word   <= '{a: d, b: cur_word.a};
      out_black   <= ~v6[GRAY_W-1];
      out_row_end <= last;
    end
  end

  assign dot_out.valid     = out_valid;
  assign dot_out.dot_black = out_black;
  assign dot_out.row_end   = out_row_end;

  `ASSERT_IMPL(a_pend_no_clash, clk, rst, pend_valid, !(acc && x_ge1), "write port clash")
  `ASSERT_NEXT(a_pend_pulse, clk, rst, pend_valid, !pend_valid, "deferred write repeated")
  `ASSERT_NEXT(a_result_held, clk, rst, acc, dot_out.valid, "transfer without result")

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// self-checking bench for atkinson_dither_unit: gray pixels are streamed in
// bursts against a stalling dot receiver, every dot is compared with a
// predicted dot, and the row width is changed between pixel phases
// ---------------------------------------------------------------------------
module tb
  import atd_pkg::*;
;

  localparam int MAX_W        = 512;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 1050;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  // predicts one dot per pixel and holds the dots still owed by the block
  class dot_scoreboard;
    typedef struct {
      logic dot_black;
      logic row_end;
    } dot_t;

    dot_t             expected_dots[$];
    logic [CFG_W-1:0] width_reg;
    int               col;
    int               rows_done;
    int               diff_prev;
    int               diff_two_back;
    int               diffs_above[MAX_W];
    int               diffs_two_above[MAX_W];
    int               errors;
    int               dots_checked;

    function new();
      width_reg     = CFG_W'(RESET_WIDTH);
      col           = 0;
      rows_done     = 0;
      diff_prev     = 0;
      diff_two_back = 0;
      errors        = 0;
      dots_checked  = 0;
      foreach (diffs_above[i]) begin
        diffs_above[i]     = 0;
        diffs_two_above[i] = 0;
      end
    endfunction

    function void set_width(logic [CFG_W-1:0] w);
      width_reg = w;
    endfunction

    function int eff_width();
      int w;
      w = width_reg;
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_W) w = MAX_W;
      return w;
    endfunction

    function int sat_add(int v, int d);
      int s;
      s = v + d;
      if (s < 0) return 0;
      if (s > 255) return 255;
      return s;
    endfunction

    function int pending();
      return expected_dots.size();
    endfunction

    function void note_pixel(gray_t gray, logic first_of_frame);
      int   w;
      int   x;
      int   v;
      int   d;
      bit   last;
      dot_t e;
      if (first_of_frame) begin
        col           = 0;
        rows_done     = 0;
        diff_prev     = 0;
        diff_two_back = 0;
      end
      w = eff_width();
      x = col;
      if (x >= MAX_W) x = MAX_W - 1;
      last = (x + 1 >= w);

      // oldest source first: two rows up, row above, then this row
      v = gray;
      if (rows_done >= 2) v = sat_add(v, diffs_two_above[x]);
      if (rows_done >= 1) begin
        if (x >= 1) v = sat_add(v, diffs_above[x-1]);
        v = sat_add(v, diffs_above[x]);
        if (!last) v = sat_add(v, diffs_above[x+1]);
      end
      if (x >= 2) v = sat_add(v, diff_two_back);
      if (x >= 1) v = sat_add(v, diff_prev);

      if (v < 128) d = v / 8;
      else d = -((255 - v) / 8);

      // line stores trail the pixel by one column
      if (x >= 1) begin
        diffs_two_above[x-1] = diffs_above[x-1];
        diffs_above[x-1]     = diff_prev;
      end
      if (last) begin
        diffs_two_above[x] = diffs_above[x];
        diffs_above[x]     = d;
      end
      diff_two_back = diff_prev;
      diff_prev     = d;

      if (last) begin
        col = 0;
        if (rows_done < 2) rows_done++;
      end else begin
        col = x + 1;
      end

      e.dot_black = (v < 128);
      e.row_end   = last;
      expected_dots.push_back(e);
    endfunction

    function void check_dot(logic black, logic row_end);
      dot_t e;
      dots_checked++;
      if (expected_dots.size() == 0) begin
        $display("%0t: unexpected dot, expected none, actual dot_black=%b row_end=%b",
                 $time, black, row_end);
        errors++;
        return;
      end
      e = expected_dots.pop_front();
      if (black !== e.dot_black) begin
        $display("%0t: dot_black mismatch, expected %b, actual %b",
                 $time, e.dot_black, black);
        errors++;
      end
      if (row_end !== e.row_end) begin
        $display("%0t: row_end mismatch, expected %b, actual %b",
                 $time, e.row_end, row_end);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               burst_left;
  bit               receiver_holding;

  atd_pix_if pix();
  atd_dot_if dot();

  dot_scoreboard sb = new();

  atkinson_dither_unit #(
    .MAX_WIDTH(MAX_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .pix_in  (pix),
    .dot_out (dot)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // note every pixel transfer before checking the dot of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pix.valid && pix.ready) sb.note_pixel(pix.gray_level, pix.frame_start);
      if (dot.valid && dot.ready) sb.check_dot(dot.dot_black, dot.row_end);
    end
  end

  // dot receiver: changing stall patterns plus two long hold-offs
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       next_hold;
    mode             = RX_STEADY;
    mode_left        = 0;
    hold_left        = 0;
    next_hold        = 150;
    dot.ready        = 1'b0;
    receiver_holding = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && next_hold > 0 && sb.dots_checked >= next_hold && pix.valid) begin
        hold_left = 80;
        next_hold = (next_hold == 150) ? 700 : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        receiver_holding = 1'b1;
        dot.ready <= 1'b0;
      end else begin
        receiver_holding = 1'b0;
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          RX_STEADY: begin
            dot.ready <= 1'b1;
          end
          RX_COIN: begin
            dot.ready <= 1'($urandom_range(0, 1));
          end
          RX_SPARSE: begin
            dot.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            dot.ready <= ~dot.ready;
          end
        endcase
      end
    end
  end

  function automatic gray_t random_gray();
    case ($urandom_range(0, 9))
      0: begin
        return 8'd0;
      end
      1: begin
        return 8'd255;
      end
      2, 3: begin
        return gray_t'($urandom_range(118, 138));
      end
      4: begin
        return gray_t'($urandom_range(0, 15));
      end
      5: begin
        return gray_t'($urandom_range(240, 255));
      end
      default: begin
        return gray_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // called just after a rising clock; returns once the pixel has transferred
  task automatic send_pixel(gray_t g, logic fs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (receiver_holding) gap = 0;
      if (gap > 0) begin
        pix.valid      <= 1'b0;
        pix.gray_level <= gray_t'($urandom_range(0, 255));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix.valid       <= 1'b1;
    pix.gray_level  <= g;
    pix.frame_start <= fs;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic wait_drained(int settle);
    pix.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_width(logic [CFG_W-1:0] w);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_width(w);
    @(posedge clk);
  endtask

  initial begin
    gray_t            reset_grays[12];
    gray_t            width3_grays[12];
    logic [CFG_W-1:0] small_widths[12];
    logic [CFG_W-1:0] new_w;
    int               items_sent;
    int               n;
    int               old_eff;
    bit               big_done;
    bit               first_fs;
    reset_grays  = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254,
                     8'd8, 8'd247, 8'd0, 8'd0, 8'd255, 8'd255};
    width3_grays = '{8'd128, 8'd127, 8'd255, 8'd0, 8'd120, 8'd135,
                     8'd64, 8'd200, 8'd100, 8'd255, 8'd0, 8'd127};
    small_widths = '{10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6,
                     10'd7, 10'd8, 10'd13, 10'd24, 10'd40, 10'd64};
    items_sent  = 0;
    big_done    = 1'b0;
    burst_left  = 0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    pix.valid       = 1'b0;
    pix.gray_level  = '0;
    pix.frame_start = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset width, no frame marker yet: no row may end this early
    for (int i = 0; i < 12; i++) send_pixel(reset_grays[i], 1'b0);

    // width 0 acts as 3; a new frame begins mid-row at the eighth pixel
    wait_drained(2);
    write_width(10'd0);
    for (int i = 0; i < 12; i++) send_pixel(width3_grays[i], (i == 0) || (i == 7));

    while (items_sent < RANDOM_ITEMS) begin
      if (!big_done && items_sent >= 260) begin
        new_w    = 10'h3FF;
        n        = MAX_W + 4;
        big_done = 1'b1;
      end else begin
        new_w = small_widths[$urandom_range(0, 11)];
        n     = $urandom_range(20, 60);
      end
      wait_drained(2);
      old_eff = sb.eff_width();
      write_width(new_w);
      // a wider row would read line entries this frame never wrote
      first_fs = (sb.eff_width() > old_eff) || ($urandom_range(0, 1) == 1);
      for (int k = 0; k < n; k++) begin
        send_pixel(random_gray(), (k == 0 && first_fs) || ($urandom_range(0, 79) == 0));
      end
      items_sent += n;
    end

    wait_drained(10);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+design
design/atd_pkg.sv
design/atd_pix_if.sv
design/atd_dot_if.sv
design/atd_ram.sv
design/atkinson_dither_unit.sv
dv/tb.sv
